[rtl/kpec_pkg.sv]
package kpec_pkg;

    // Register indexes
    localparam logic [2:0] REG_DEB_INTERVAL = 3'd0;
    localparam logic [2:0] REG_DEB_COUNT    = 3'd1;
    localparam logic [2:0] REG_LONG_TICKS   = 3'd2;
    localparam logic [2:0] REG_CLICK_WINDOW = 3'd3;
    localparam logic [2:0] REG_KEY_ENABLE   = 3'd4;
    localparam logic [2:0] REG_EVENT_ENABLE = 3'd5;

    // Reset values
    localparam logic [15:0] RST_DEB_INTERVAL = 16'd20;
    localparam logic [7:0]  RST_DEB_COUNT    = 8'd1;
    localparam logic [15:0] RST_LONG_TICKS   = 16'd1000;
    localparam logic [15:0] RST_CLICK_WINDOW = 16'd800;
    localparam logic [7:0]  RST_KEY_ENABLE   = 8'd0;
    localparam logic [4:0]  RST_EVENT_ENABLE = 5'd31;

    localparam int DEF_KEYS  = 8;
    localparam int LVL_BITS  = 8;
    localparam int CFG_WIDTH = 16;

    // Event enable bits
    localparam int EN_STATUS = 0;
    localparam int EN_SHORT  = 1;
    localparam int EN_LONG   = 2;
    localparam int EN_HOLD   = 3;
    localparam int EN_MULTI  = 4;

    typedef enum logic [2:0] {
        EV_SUMMARY  = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_SHORT    = 3'd3,
        EV_LONG     = 3'd4,
        EV_HOLD     = 3'd5,
        EV_MULTI    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMP,
        ST_MUL,
        ST_EVT,
        ST_REL,
        ST_WIN,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [7:0]  key_levels;
        logic [31:0] now_time;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [2:0]  key_index;
        logic [31:0] duration;
        logic [15:0] count;
        logic        busy_res;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] deb_interval;
        logic [7:0]  deb_count;
        logic [15:0] long_ticks;
        logic [15:0] click_window;
        logic [7:0]  key_enable;
        logic [4:0]  event_enable;
        logic [7:0]  key_clear;
    } t_cfg;

endpackage

[rtl/kpec_cfg.sv]
module kpec_cfg
    import kpec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,
    output t_cfg                 o_cfg
);

    logic [15:0] r_deb_interval;
    logic [7:0]  r_deb_count;
    logic [15:0] r_long_ticks;
    logic [15:0] r_click_window;
    logic [7:0]  r_key_enable;
    logic [4:0]  r_event_enable;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_interval <= RST_DEB_INTERVAL;
            r_deb_count    <= RST_DEB_COUNT;
            r_long_ticks   <= RST_LONG_TICKS;
            r_click_window <= RST_CLICK_WINDOW;
            r_key_enable   <= RST_KEY_ENABLE;
            r_event_enable <= RST_EVENT_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEB_INTERVAL: r_deb_interval <= i_cfg_wdata;
                REG_DEB_COUNT:    r_deb_count    <= i_cfg_wdata[7:0];
                REG_LONG_TICKS:   r_long_ticks   <= i_cfg_wdata;
                REG_CLICK_WINDOW: r_click_window <= i_cfg_wdata;
                REG_KEY_ENABLE:   r_key_enable   <= i_cfg_wdata[7:0];
                REG_EVENT_ENABLE: r_event_enable <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Drive the configuration outputs; flag keys whose enable bit rises on this write
    always_comb begin
        o_cfg.deb_interval = r_deb_interval;
        o_cfg.deb_count    = r_deb_count;
        o_cfg.long_ticks   = r_long_ticks;
        o_cfg.click_window = r_click_window;
        o_cfg.key_enable   = r_key_enable;
        o_cfg.event_enable = r_event_enable;
        o_cfg.key_clear    = (i_cfg_we && i_cfg_index == REG_KEY_ENABLE) ?
                             (i_cfg_wdata[7:0] & ~r_key_enable) : 8'd0;
    end

endmodule

[rtl/kpec_mul.sv]
module kpec_mul
    import kpec_pkg::*;
(
    input  logic        i_clk,
    input  logic [16:0] i_a,
    input  logic [15:0] i_b,
    output logic [31:0] o_p
);

    logic [31:0] r_p;

    // Register product; i_a reaches at most 65536 and i_b at most 65535
    always_ff @(posedge i_clk) begin
        r_p <= 32'(i_a * i_b);
    end

    assign o_p = r_p;

endmodule

[rtl/key_press_event_classifier.sv]
// Key press event classifier.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one scan word:
// raw levels of up to eight keys and the current tick. Output channel
// (o_out_valid / i_out_ready / o_out_data) delivers event words: pressed,
// hold repeat, short or long, released per key in key order, then
// multi-click per key, then one summary word with last set.
// The user writes configuration through i_cfg_we / i_cfg_index / i_cfg_wdata
// only while no scan is in progress; the block does not enforce this. Enabling
// a key clears its press state. One scan is handled by a sequencer that visits
// each key: sample, multiply, evaluate (plus a released step that follows
// short/long), then a window step per key and one summary step. The hold repeat
// test runs through one registered multiplier shared by all keys.
// o_in_ready is high only between scans. When the receiver stalls, the
// single output register holds its word and the sequencer waits.
// Reset (synchronous, active low) restores register defaults, clears all
// key state and drops any pending output word.
module key_press_event_classifier
    import kpec_pkg::*;
#(
    parameter int KEYS = DEF_KEYS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata
);

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [KW-1:0] KEY_LAST = KW'(KEYS - 1);

    t_cfg cfg;

    kpec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Per-key state
    logic        r_tent  [KEYS];
    logic        r_conf  [KEYS];
    logic        r_held  [KEYS];
    logic [31:0] r_ss    [KEYS];
    logic [7:0]  r_ccnt  [KEYS];
    logic [31:0] r_ps    [KEYS];
    logic [31:0] r_pd    [KEYS];
    logic [15:0] r_hc    [KEYS];
    logic [31:0] r_cs    [KEYS];
    logic        r_cp    [KEYS];
    logic [15:0] r_clk_n [KEYS];

    t_state      r_state, n_state;
    logic [KW-1:0] r_key, n_key;
    logic [7:0]  r_lvl;
    logic [31:0] r_now;
    logic        r_busy, n_busy;
    logic        r_ovalid, n_ovalid;
    t_out        r_out, n_out;

    // Next values for the visited key
    logic        n_tent, n_conf, n_held, n_cp;
    logic [31:0] n_ss, n_ps, n_pd, n_cs;
    logic [7:0]  n_ccnt;
    logic [15:0] n_hc, n_clk_n;
    logic        key_we;

    logic [15:0] lp;
    logic [31:0] prod;
    logic [4:0]  kidx;
    logic        en, lvl, slot, emit, is_last, accept;
    logic [31:0] d_ss, d_ps, d_cs;
    logic [32:0] prod_hi;
    logic [7:0]  ccnt_inc;
    t_kind       kind;

    assign lp = (cfg.long_ticks == 16'd0) ? 16'd1 : cfg.long_ticks;

    kpec_mul u_mul (
        .i_clk (i_clk),
        .i_a   (17'(r_hc[r_key]) + 17'd1),
        .i_b   (lp),
        .o_p   (prod)
    );

    assign accept  = i_in_valid && o_in_ready;
    assign slot    = !r_ovalid || i_out_ready;
    assign kidx    = 5'(r_key);
    assign is_last = (r_key == KEY_LAST);

    // Sequencer and per-key evaluation
    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_busy   = r_busy;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        emit     = 1'b0;
        kind     = EV_SUMMARY;
        key_we   = 1'b0;
        n_tent   = r_tent[r_key];
        n_conf   = r_conf[r_key];
        n_held   = r_held[r_key];
        n_ss     = r_ss[r_key];
        n_ccnt   = r_ccnt[r_key];
        n_ps     = r_ps[r_key];
        n_pd     = r_pd[r_key];
        n_hc     = r_hc[r_key];
        n_cs     = r_cs[r_key];
        n_cp     = r_cp[r_key];
        n_clk_n  = r_clk_n[r_key];
        en       = (kidx < 5'd8) && cfg.key_enable[kidx[2:0]];
        lvl      = (kidx < 5'd8) && r_lvl[kidx[2:0]];
        d_ss     = r_now - r_ss[r_key];
        d_ps     = r_now - r_ps[r_key];
        d_cs     = r_now - r_cs[r_key];
        prod_hi  = 33'(prod) + 33'(lp);
        ccnt_inc = r_ccnt[r_key] + 8'd1;
        n_out.key_index = 3'(r_key);
        n_out.duration  = 32'd0;
        n_out.count     = 16'd0;
        n_out.busy_res  = 1'b0;
        n_out.last      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SAMP;
                    n_key   = '0;
                    n_busy  = 1'b0;
                end
            end
            // Debounce sampling
            ST_SAMP: begin
                key_we  = 1'b1;
                n_state = ST_MUL;
                if (en) begin
                    if (r_tent[r_key] && !r_conf[r_key]) begin
                        if (d_ss >= 32'(cfg.deb_interval)) begin
                            if (lvl) begin
                                n_ccnt = ccnt_inc;
                                n_ss   = r_now;
                                if (ccnt_inc >= cfg.deb_count) begin
                                    n_conf = 1'b1;
                                    n_ccnt = 8'd0;
                                end
                            end else begin
                                n_tent = 1'b0;
                                n_conf = 1'b0;
                                n_ss   = 32'd0;
                                n_ccnt = 8'd0;
                            end
                        end
                    end else if (r_conf[r_key]) begin
                        if (!lvl) begin
                            n_tent = 1'b0;
                            n_conf = 1'b0;
                            n_ss   = 32'd0;
                            n_ccnt = 8'd0;
                        end
                    end else begin
                        n_tent = lvl;
                        if (lvl) n_ss = r_now;
                    end
                end
            end
            // Wait for the hold threshold product
            ST_MUL: begin
                n_state = ST_EVT;
            end
            // Press, hold repeat, short/long, or release classification
            ST_EVT: begin
                if (slot) begin
                    key_we  = 1'b1;
                    n_state = is_last ? ST_WIN : ST_SAMP;
                    n_key   = is_last ? '0 : r_key + KW'(1);
                    if (r_conf[r_key]) begin
                        n_held = 1'b1;
                        if (!r_held[r_key]) begin
                            n_ps = r_now;
                            emit = cfg.event_enable[EN_STATUS];
                            kind = EV_PRESSED;
                        end else if (cfg.event_enable[EN_HOLD] && r_hc[r_key] != 16'hFFFF
                                     && d_ps >= prod && 33'(d_ps) < prod_hi) begin
                            n_hc = r_hc[r_key] + 16'd1;
                            emit = 1'b1;
                            kind = EV_HOLD;
                            n_out.count = r_hc[r_key] + 16'd1;
                        end
                    end else if (r_held[r_key]) begin
                        n_held = 1'b0;
                        n_hc   = 16'd0;
                        n_pd   = d_ps;
                        n_cs   = r_now;
                        n_cp   = 1'b1;
                        if (r_clk_n[r_key] != 16'hFFFF) n_clk_n = r_clk_n[r_key] + 16'd1;
                        if (d_ps >= 32'(lp)) begin
                            emit = cfg.event_enable[EN_LONG];
                            kind = EV_LONG;
                            n_out.duration = d_ps;
                        end else begin
                            emit = cfg.event_enable[EN_SHORT];
                            kind = EV_SHORT;
                        end
                        if (emit) begin
                            // hold the key; released follows next
                            n_state = ST_REL;
                            n_key   = r_key;
                        end else begin
                            emit = cfg.event_enable[EN_STATUS];
                            kind = EV_RELEASED;
                        end
                    end
                end
            end
            ST_REL: begin
                if (slot) begin
                    emit    = cfg.event_enable[EN_STATUS];
                    kind    = EV_RELEASED;
                    n_state = is_last ? ST_WIN : ST_SAMP;
                    n_key   = is_last ? '0 : r_key + KW'(1);
                end
            end
            // Close click windows and gather the busy flag
            ST_WIN: begin
                if (slot) begin
                    key_we  = 1'b1;
                    n_state = is_last ? ST_SUM : ST_WIN;
                    n_key   = is_last ? '0 : r_key + KW'(1);
                    if (r_cp[r_key] && d_cs > 32'(cfg.click_window)) begin
                        emit = (r_clk_n[r_key] > 16'd1) && cfg.event_enable[EN_MULTI];
                        kind = EV_MULTI;
                        n_out.duration = r_pd[r_key];
                        n_out.count    = r_clk_n[r_key];
                        n_clk_n = 16'd0;
                        n_cp    = 1'b0;
                    end
                    n_busy = r_busy || n_cp || r_held[r_key] || r_tent[r_key];
                end
            end
            ST_SUM: begin
                if (slot) begin
                    emit = 1'b1;
                    kind = EV_SUMMARY;
                    n_out.key_index = 3'd0;
                    n_out.busy_res  = r_busy;
                    n_out.last      = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out.event_kind = kind;
        if (emit) n_ovalid = 1'b1;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_key    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_key    <= n_key;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    // Capture scan word and output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lvl <= i_in_data.key_levels;
            r_now <= i_in_data.now_time;
        end
        if (emit) r_out <= n_out;
    end

    // Key state: clear on reset, else update visited key, else clear on enable rise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_tent[k]  <= 1'b0;
                r_conf[k]  <= 1'b0;
                r_held[k]  <= 1'b0;
                r_ss[k]    <= 32'd0;
                r_ccnt[k]  <= 8'd0;
                r_ps[k]    <= 32'd0;
                r_pd[k]    <= 32'd0;
                r_hc[k]    <= 16'd0;
                r_cs[k]    <= 32'd0;
                r_cp[k]    <= 1'b0;
                r_clk_n[k] <= 16'd0;
            end
        end else if (key_we) begin
            r_tent[r_key]  <= n_tent;
            r_conf[r_key]  <= n_conf;
            r_held[r_key]  <= n_held;
            r_ss[r_key]    <= n_ss;
            r_ccnt[r_key]  <= n_ccnt;
            r_ps[r_key]    <= n_ps;
            r_pd[r_key]    <= n_pd;
            r_hc[r_key]    <= n_hc;
            r_cs[r_key]    <= n_cs;
            r_cp[r_key]    <= n_cp;
            r_clk_n[r_key] <= n_clk_n;
        end else begin
            for (int k = 0; k < KEYS && k < LVL_BITS; k++) begin
                if (cfg.key_clear[k]) begin
                    r_tent[k]  <= 1'b0;
                    r_conf[k]  <= 1'b0;
                    r_held[k]  <= 1'b0;
                    r_ps[k]    <= 32'd0;
                    r_pd[k]    <= 32'd0;
                    r_hc[k]    <= 16'd0;
                    r_cp[k]    <= 1'b0;
                    r_clk_n[k] <= 16'd0;
                end
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Checks
    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.event_kind == EV_SUMMARY)))
        else $error("last flag does not match summary word");

    a_hold_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_kind == EV_HOLD) |-> (o_out_data.count != 16'd0))
        else $error("hold repeat word with zero count");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SAMP && r_key == '0))
        else $error("scan did not start at first key");

    a_summary_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && slot) |=> (o_out_valid && o_out_data.last && o_in_ready))
        else $error("summary not issued before idle");

endmodule
